// ===== hw/rtl/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types, constants and helpers for the integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;

  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(MAX_DIM);
  localparam int MUL_W     = 2 * ELEM_BITS;
  localparam int PROD_W    = 35;
  localparam int EXT_W     = (MUL_W > PROD_W) ? MUL_W : PROD_W;

  // Fixed field widths
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 3;
  localparam int VALUE_W   = 16;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_WR_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Tag travelling alongside the read data through the MAC pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  // Last loop index for a dimension register; 0 acts as 1, large values saturate
  function automatic logic [CNT_W-1:0] dim_last(input logic [DIM_W-1:0] d);
    int v;
    v = int'(d);
    if (v < 1) v = 1;
    if (v > MAX_DIM) v = MAX_DIM;
    return CNT_W'(v - 1);
  endfunction

  function automatic logic [AW-1:0] mem_addr(input int row, input int col);
    return AW'(row * MAX_DIM + col);
  endfunction

endpackage

// ===== hw/rtl/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/imm_mac.sv =====
// ----------------------------------------------------------------------------
// imm_mac
// Shared multiply-accumulate unit: registered multiply, then accumulate.
// ----------------------------------------------------------------------------
module imm_mac
  import imm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [ELEM_BITS-1:0] a_i,
  input  logic signed [ELEM_BITS-1:0] b_i,
  output logic signed [PROD_W-1:0] acc_o,
  output logic                     done_o
);

  logic signed [MUL_W-1:0]  mul_q;
  mac_ctrl_t                mul_ctrl_q;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic signed [EXT_W-1:0]  mul_ext;
  logic signed [PROD_W-1:0] mul_trim;
  logic                     done_q;

  always_ff @(posedge clk_i) begin
    mul_q <= a_i * b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_ctrl_q <= '0;
      done_q     <= 1'b0;
    end else begin
      mul_ctrl_q <= ctrl_i;
      done_q     <= mul_ctrl_q.valid && mul_ctrl_q.last;
    end
  end

  // Sums wrap modulo 2^PROD_W
  assign mul_ext  = EXT_W'(mul_q);
  assign mul_trim = mul_ext[PROD_W-1:0];

  always_comb begin
    acc_d = acc_q;
    if (mul_ctrl_q.valid) begin
      acc_d = mul_ctrl_q.first ? mul_trim : acc_q + mul_trim;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/integer_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Loads A and B element by element, then streams C = A * B in row-major order.
// ----------------------------------------------------------------------------
// Write transactions are accepted back to back while no run is in progress.
// A start walks every product element with one shared MAC: inner_dim store
// reads, then a drain of the MAC pipeline, then hand-off to the output
// register, which waits while the receiver stalls. Input is stalled for
// the run. Reset sets all dimensions to 8; the stores are not cleared and
// hold undefined data until written.
module integer_matrix_multiply
  import imm_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [KIND_W-1:0]           in_kind_i,
  input  logic [IDX_W-1:0]            in_row_i,
  input  logic [IDX_W-1:0]            in_col_i,
  input  logic signed [VALUE_W-1:0]   in_value_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [IDX_W-1:0]            out_row_o,
  output logic [IDX_W-1:0]            out_col_o,
  output logic signed [PROD_W-1:0]    out_product_o,
  output logic                        out_last_o,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [DIM_W-1:0]            cfg_data_i
);

  state_e state_q, state_d;

  logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [CNT_W-1:0] r_q, c_q, k_q;
  logic [CNT_W-1:0] nr_last, nk_last, nc_last;

  logic in_accept, start, wr_ok, we_a, we_b;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic signed [ELEM_BITS-1:0] wdata, rdata_a, rdata_b;

  logic issue, load_out, el_last;
  mac_ctrl_t iss_q;
  logic signed [PROD_W-1:0] acc;
  logic mac_done;

  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [PROD_W-1:0] out_product_q;
  logic                     out_last_q;

  // ---- configuration ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        REG_COLS_B:    cols_b_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign nr_last = dim_last(rows_a_q);
  assign nk_last = dim_last(inner_dim_q);
  assign nc_last = dim_last(cols_b_q);

  // ---- input side ----
  assign in_accept = in_valid_i && !in_stall_o;
  assign start     = in_accept && (in_kind_i == KIND_START);
  assign wr_ok     = (int'(in_row_i) < MAX_DIM) && (int'(in_col_i) < MAX_DIM);
  assign we_a      = in_accept && wr_ok && (in_kind_i == KIND_WR_A);
  assign we_b      = in_accept && wr_ok && (in_kind_i == KIND_WR_B);
  assign waddr     = mem_addr(int'(in_row_i), int'(in_col_i));
  assign wdata     = ELEM_BITS'(in_value_i);

  assign raddr_a   = mem_addr(int'(r_q), int'(k_q));
  assign raddr_b   = mem_addr(int'(k_q), int'(c_q));

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // ---- sequencer ----
  assign el_last = (r_q == nr_last) && (c_q == nc_last);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_RUN;
      ST_RUN:   if (k_q == nk_last) state_d = ST_DRAIN;
      ST_DRAIN: if (mac_done) state_d = ST_EMIT;
      ST_EMIT:  if (load_out) state_d = el_last ? ST_IDLE : ST_RUN;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    issue      = (state_q == ST_RUN);
    load_out   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      iss_q   <= '0;
    end else begin
      state_q     <= state_d;
      iss_q.valid <= issue;
      iss_q.first <= (k_q == '0);
      iss_q.last  <= (k_q == nk_last);
      if (start) begin
        r_q <= '0;
        c_q <= '0;
        k_q <= '0;
      end else if (issue) begin
        k_q <= (k_q == nk_last) ? '0 : k_q + 1'b1;
      end else if (load_out && !el_last) begin
        if (c_q == nc_last) begin
          c_q <= '0;
          r_q <= r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
    end
  end

  imm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (iss_q),
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_row_q     <= IDX_W'(r_q);
      out_col_q     <= IDX_W'(c_q);
      out_product_q <= acc;
      out_last_q    <= el_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_product_o = out_product_q;
  assign out_last_o    = out_last_q;

  // ---- assertions ----
  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == ST_DRAIN)
    else $error("MAC finished outside drain");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |=> state_q == ST_RUN || state_q == ST_DRAIN)
    else $error("run left without draining");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> state_q == ST_RUN && k_q == '0 && r_q == '0 && c_q == '0)
    else $error("start did not reset loop counters");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o |->
      out_row_o == IDX_W'(nr_last) && out_col_o == IDX_W'(nc_last))
    else $error("last flag on wrong element");

endmodule

// ===== bench/integer_matrix_multiply_tb.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_tb
// Self-checking bench for the integer matrix multiply block.
// A and B elements are loaded and multiplications started under a range of
// dimension settings. Every product is predicted at the moment its start is
// accepted and is compared field by field as it leaves the block. The sender
// works in bursts and the receiver stalls, including one long hold-off.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imm_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_NONE = 2'd3;     // unused kind, ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE  = 2'd3;     // unused register index
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 16'sh7FFF;
  localparam logic signed [VALUE_W-1:0] VAL_NEG = 16'shFFFF;
  localparam logic signed [VALUE_W-1:0] VAL_ZERO = 16'sh0000;

  localparam int ITEM_TARGET  = 430;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int STALL_PCT [4] = '{0, 30, 60, 90};

  typedef struct {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [PROD_W-1:0] product;
    logic                     last;
  } product_elem_t;

  // Keeps its own copy of both stores and the dimension registers and
  // queues the product elements each start transaction must produce.
  class matmul_checker;
    logic signed [ELEM_BITS-1:0] a_elems [DEPTH];
    logic signed [ELEM_BITS-1:0] b_elems [DEPTH];
    logic [DIM_W-1:0]            dims [3];
    product_elem_t               expected_products [$];
    int                          n_errors;
    int                          n_results;

    function new();
      foreach (a_elems[i]) begin
        a_elems[i] = '0;
        b_elems[i] = '0;
      end
      dims[0]   = DIM_RESET;
      dims[1]   = DIM_RESET;
      dims[2]   = DIM_RESET;
      n_errors  = 0;
      n_results = 0;
    endfunction

    // zero acts as one, anything above MAX_DIM saturates
    function int eff_dim(logic [DIM_W-1:0] d);
      if (d == '0) return 1;
      if (int'(d) > MAX_DIM) return MAX_DIM;
      return int'(d);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        REG_ROWS_A:    dims[0] = data;
        REG_INNER_DIM: dims[1] = data;
        REG_COLS_B:    dims[2] = data;
        default: ;
      endcase
    endfunction

    function void note_transaction(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] row,
                                   logic [IDX_W-1:0] col,
                                   logic signed [VALUE_W-1:0] value);
      int nr, nk, nc;
      logic signed [PROD_W-1:0] acc;
      product_elem_t e;
      case (kind)
        KIND_WR_A: a_elems[int'(row) * MAX_DIM + int'(col)] = value;
        KIND_WR_B: b_elems[int'(row) * MAX_DIM + int'(col)] = value;
        KIND_START: begin
          nr = eff_dim(dims[0]);
          nk = eff_dim(dims[1]);
          nc = eff_dim(dims[2]);
          for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
              acc = '0;
              for (int k = 0; k < nk; k++)
                acc = acc + a_elems[r * MAX_DIM + k] * b_elems[k * MAX_DIM + c];
              e.row     = IDX_W'(r);
              e.col     = IDX_W'(c);
              e.product = acc;
              e.last    = (r == nr - 1) && (c == nc - 1);
              expected_products.push_back(e);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_product(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic signed [PROD_W-1:0] product, logic last);
      product_elem_t e;
      n_results++;
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected product row %0d col %0d value %0d last %0b",
                 $time, row, col, product, last);
        n_errors++;
        return;
      end
      e = expected_products.pop_front();
      if (row !== e.row) begin
        $display("%0t: out_row mismatch: expected %0d, actual %0d", $time, e.row, row);
        n_errors++;
      end
      if (col !== e.col) begin
        $display("%0t: out_col mismatch: expected %0d, actual %0d", $time, e.col, col);
        n_errors++;
      end
      if (product !== e.product) begin
        $display("%0t: product mismatch at (%0d,%0d): expected %0d, actual %0d",
                 $time, e.row, e.col, e.product, product);
        n_errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last mismatch at (%0d,%0d): expected %0b, actual %0b",
                 $time, e.row, e.col, e.last, last);
        n_errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [KIND_W-1:0]         in_kind_i;
  logic [IDX_W-1:0]          in_row_i;
  logic [IDX_W-1:0]          in_col_i;
  logic signed [VALUE_W-1:0] in_value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [IDX_W-1:0]          out_row_o;
  logic [IDX_W-1:0]          out_col_o;
  logic signed [PROD_W-1:0]  out_product_o;
  logic                      out_last_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [DIM_W-1:0]          cfg_data_i;

  matmul_checker sb = new();

  // entries loaded so far; a start never reads one that is still clear
  bit a_loaded [DEPTH];
  bit b_loaded [DEPTH];

  int items_sent;
  int starts_sent;
  int cfg_writes;
  int burst_left;
  int cycle_count;

  integer_matrix_multiply i_dut (.*);

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d products outstanding",
               cycle_count, sb.expected_products.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_product(out_row_o, out_col_o, out_product_o, out_last_o);
  end

  // Receiver: stretches of differing stall density, one long hold-off
  initial begin : result_sink
    int  pct;
    int  span;
    bit  held;
    held        = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      pct  = STALL_PCT[$urandom_range(0, 3)];
      span = $urandom_range(5, 80);
      if (!held && sb.n_results >= HOLD_AFTER) begin
        held = 1'b1;
        pct  = 100;
        span = HOLD_CYCLES;
      end
      repeat (span) begin
        @(negedge clk_i);
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return VAL_ZERO;
      3: return VAL_NEG;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col,
                           input logic signed [VALUE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_row_i   <= row;
    in_col_i   <= col;
    in_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transaction(kind, row, col, value);
    if (kind == KIND_WR_A) a_loaded[int'(row) * MAX_DIM + int'(col)] = 1'b1;
    if (kind == KIND_WR_B) b_loaded[int'(row) * MAX_DIM + int'(col)] = 1'b1;
    if (kind == KIND_START) starts_sent++;
    items_sent++;
  endtask

  // Sender pauses until every product has come back and the block has settled
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_products.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ka,
                          input logic [DIM_W-1:0] ca);
    wait_drained();
    write_reg(REG_ROWS_A, ra);
    write_reg(REG_INNER_DIM, ka);
    write_reg(REG_COLS_B, ca);
  endtask

  // Stray loads, a refresh of part of the operands with any gaps filled, an
  // occasional unused-kind item, then one start (occasionally repeated).
  task automatic run_round(input int nr, input int nk, input int nc);
    int n;
    n = $urandom_range(0, 5);
    repeat (n)
      send_item($urandom_range(0, 1) ? KIND_WR_B : KIND_WR_A, IDX_W'($urandom_range(0, 7)),
                IDX_W'($urandom_range(0, 7)), pick_value());
    for (int r = 0; r < nr; r++)
      for (int k = 0; k < nk; k++)
        if (!a_loaded[r * MAX_DIM + k] || $urandom_range(0, 3) == 0)
          send_item(KIND_WR_A, IDX_W'(r), IDX_W'(k), pick_value());
    for (int k = 0; k < nk; k++)
      for (int c = 0; c < nc; c++)
        if (!b_loaded[k * MAX_DIM + c] || $urandom_range(0, 3) == 0)
          send_item(KIND_WR_B, IDX_W'(k), IDX_W'(c), pick_value());
    if ($urandom_range(0, 9) == 0)
      send_item(KIND_NONE, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                pick_value());
    send_item(KIND_START, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
              pick_value());
    if ($urandom_range(0, 5) == 0)
      send_item(KIND_START, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                pick_value());
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] ra, ka, ca;
    int               phase;
    int               rounds;
    in_valid_i  = 1'b0;
    in_kind_i   = KIND_WR_A;
    in_row_i    = '0;
    in_col_i    = '0;
    in_value_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ROWS_A;
    cfg_data_i  = '0;
    items_sent  = 0;
    starts_sent = 0;
    cfg_writes  = 0;
    burst_left  = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: unused register index, 1x1x1 at the value extremes
    write_reg(REG_NONE, 4'hF);
    set_dims(4'd1, 4'd1, 4'd1);
    send_item(KIND_WR_A, 3'd0, 3'd0, VAL_MIN);
    send_item(KIND_WR_B, 3'd0, 3'd0, VAL_MIN);
    send_item(KIND_START, 3'd0, 3'd0, VAL_ZERO);
    send_item(KIND_WR_A, 3'd0, 3'd0, VAL_MAX);
    send_item(KIND_START, 3'd7, 3'd7, VAL_NEG);
    // unused kind is dropped; loads outside the active shape leave it alone
    send_item(KIND_NONE, 3'd7, 3'd7, VAL_NEG);
    send_item(KIND_WR_A, 3'd7, 3'd7, VAL_MAX);
    send_item(KIND_WR_B, 3'd7, 3'd7, VAL_MIN);
    send_item(KIND_START, 3'd0, 3'd0, VAL_MAX);

    set_dims(4'd2, 4'd2, 4'd2);
    send_item(KIND_WR_A, 3'd0, 3'd0, VAL_MAX);
    send_item(KIND_WR_A, 3'd0, 3'd1, VAL_MAX);
    send_item(KIND_WR_A, 3'd1, 3'd0, VAL_MIN);
    send_item(KIND_WR_A, 3'd1, 3'd1, VAL_NEG);
    send_item(KIND_WR_B, 3'd0, 3'd0, VAL_MIN);
    send_item(KIND_WR_B, 3'd0, 3'd1, VAL_MAX);
    send_item(KIND_WR_B, 3'd1, 3'd0, VAL_ZERO);
    send_item(KIND_WR_B, 3'd1, 3'd1, VAL_NEG);
    send_item(KIND_START, 3'd0, 3'd0, VAL_ZERO);

    // random phases; the first few pin the register extremes
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin ra = 4'd0;  ka = 4'd0;  ca = 4'd0;  end
        1: begin ra = 4'd15; ka = 4'd15; ca = 4'd15; end
        2: begin ra = 4'd8;  ka = 4'd1;  ca = 4'd8;  end
        3: begin ra = 4'd1;  ka = 4'd8;  ca = 4'd1;  end
        4: begin ra = 4'd9;  ka = 4'd3;  ca = 4'd12; end
        default: begin
          ra = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 15))
                                           : DIM_W'($urandom_range(1, 4));
          ka = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 15))
                                           : DIM_W'($urandom_range(1, 4));
          ca = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 15))
                                           : DIM_W'($urandom_range(1, 4));
        end
      endcase
      set_dims(ra, ka, ca);
      // full-size phase keeps offering work while the receiver holds off
      rounds = (phase == 1) ? 3 : $urandom_range(1, 3);
      repeat (rounds) run_round(sb.eff_dim(ra), sb.eff_dim(ka), sb.eff_dim(ca));
      phase++;
    end
    wait_drained();

    $display("%0d input transactions (%0d starts), %0d config writes, %0d phases",
             items_sent, starts_sent, cfg_writes, phase + 2);
    $display("%0d product elements checked, %0d errors", sb.n_results, sb.n_errors);
    if (sb.n_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/imm_pkg.sv
hw/rtl/imm_ram.sv
hw/rtl/imm_mac.sv
hw/rtl/integer_matrix_multiply.sv
bench/integer_matrix_multiply_tb.sv
